FILE: design/selective_repeat_receiver_macros.svh
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// same-cycle implication
`define SRR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("selective repeat receiver check failed");

// next-cycle implication
`define SRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("selective repeat receiver check failed");

`endif

FILE: design/srr_pkg.sv
package srr_pkg;

  localparam int WINDOW_DEPTH  = 32;
  localparam int PAYLOAD_BYTES = 20;
  localparam int SEQ_W         = 16;
  localparam int IN_CHK_W      = 18;
  localparam int OUT_CHK_W     = 17;
  localparam int LOW_W         = 64;
  localparam int MID_W         = 64;
  localparam int HIGH_W        = 32;
  localparam int PAYLOAD_W     = LOW_W + MID_W + HIGH_W;
  localparam int SUM_W         = 19;
  localparam int BYTE_IDX_W    = $clog2(PAYLOAD_BYTES);

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

endpackage

FILE: design/srr_if.sv
interface srr_rx_if;
  logic                                      valid;
  logic                                      ready;
  srr_pkg::seq_t                             in_sequence;
  srr_pkg::seq_t                             in_ack_number;
  logic signed [srr_pkg::IN_CHK_W-1:0]       in_checksum;
  logic [srr_pkg::LOW_W-1:0]                 in_payload_low;
  logic [srr_pkg::MID_W-1:0]                 in_payload_mid;
  logic [srr_pkg::HIGH_W-1:0]                in_payload_high;

  modport source (output valid, in_sequence, in_ack_number, in_checksum,
                  in_payload_low, in_payload_mid, in_payload_high, input ready);
  modport sink   (input valid, in_sequence, in_ack_number, in_checksum,
                  in_payload_low, in_payload_mid, in_payload_high, output ready);
endinterface

interface srr_tx_if;
  logic                           valid;
  logic                           ready;
  logic                           out_kind;
  srr_pkg::seq_t                  out_sequence;
  logic [srr_pkg::OUT_CHK_W-1:0]  out_checksum;
  logic [srr_pkg::LOW_W-1:0]      out_payload_low;
  logic [srr_pkg::MID_W-1:0]      out_payload_mid;
  logic [srr_pkg::HIGH_W-1:0]     out_payload_high;
  logic                           out_last;

  modport source (output valid, out_kind, out_sequence, out_checksum, out_payload_low,
                  out_payload_mid, out_payload_high, out_last, input ready);
  modport sink   (input valid, out_kind, out_sequence, out_checksum, out_payload_low,
                  out_payload_mid, out_payload_high, out_last, output ready);
endinterface

FILE: design/srr_ram.sv
module srr_ram #(
  parameter int WIDTH = srr_pkg::PAYLOAD_W,
  parameter int DEPTH = srr_pkg::WINDOW_DEPTH
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/selective_repeat_receiver.sv
// Flow: a packet is accepted, then its 20 payload bytes are summed, then a decide step.
// Dropped packet: ready again after the decide step; re-ack only: after the ack is loaded.
// In-window packet releasing k deliveries: each delivery takes a slot RAM read and an
// output load that waits for tx.ready, then an ack follows; one item accepted at a time.
// Sync reset clears next expected, head, slot valid bits and output valid;
// the slot RAM has no reset and needs no clearing pass.
module selective_repeat_receiver #(
  parameter int WINDOW_DEPTH = srr_pkg::WINDOW_DEPTH
) (
  input logic       clk,
  input logic       rst,
  srr_rx_if.sink    rx,
  srr_tx_if.source  tx
);

  localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SEQ_W      = srr_pkg::SEQ_W;
  localparam int SUM_W      = srr_pkg::SUM_W;
  localparam int BYTE_IDX_W = srr_pkg::BYTE_IDX_W;

  localparam logic [SEQ_W-1:0]      WIN_SIZE    = SEQ_W'(WINDOW_DEPTH);
  localparam logic [SEQ_W-1:0]      BELOW_START = SEQ_W'((1 << SEQ_W) - WINDOW_DEPTH);
  localparam logic [IDX_W:0]        DEPTH_EXT   = (IDX_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]      LAST_IDX    = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE   = BYTE_IDX_W'(srr_pkg::PAYLOAD_BYTES - 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SUM       = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_DRAIN_RD  = 3'd3;
  localparam logic [2:0] S_DRAIN_OUT = 3'd4;
  localparam logic [2:0] S_ACK       = 3'd5;

  logic [2:0]                          state;
  srr_pkg::seq_t                       seq;
  logic signed [srr_pkg::IN_CHK_W-1:0] given;
  srr_pkg::payload_t                   payload;
  logic signed [SUM_W-1:0]             acc;
  logic [BYTE_IDX_W-1:0]               byte_cnt;
  srr_pkg::seq_t                       next_expected;
  logic [IDX_W-1:0]                    head;
  logic [WINDOW_DEPTH-1:0]             slot_valid;

  logic                                out_valid;
  logic                                out_kind;
  srr_pkg::seq_t                       out_sequence;
  logic [srr_pkg::OUT_CHK_W-1:0]       out_checksum;
  srr_pkg::payload_t                   out_payload;
  logic                                out_last;

  logic                                accept;
  logic signed [7:0]                   cur_byte;
  logic                                sum_ok;
  srr_pkg::seq_t                       offset;
  logic                                in_window;
  logic                                below_window;
  logic [IDX_W:0]                      slot_sum;
  logic [IDX_W-1:0]                    slot_idx;
  logic [IDX_W-1:0]                    head_next;
  logic                                out_free;
  logic                                load_dlv;
  logic                                load_ack;
  logic                                ram_we;
  logic                                ram_re;
  srr_pkg::payload_t                   ram_rdata;

  assign rx.ready = (state == S_IDLE);
  assign accept   = rx.valid && rx.ready;

  assign cur_byte     = payload[byte_cnt * 8 +: 8];
  assign sum_ok       = (acc == SUM_W'(given));
  assign offset       = seq - next_expected;
  assign in_window    = (offset < WIN_SIZE);
  assign below_window = (offset >= BELOW_START);
  assign slot_sum     = {1'b0, head} + {1'b0, offset[IDX_W-1:0]};
  assign slot_idx     = (slot_sum >= DEPTH_EXT) ? IDX_W'(slot_sum - DEPTH_EXT)
                                                : slot_sum[IDX_W-1:0];
  assign head_next    = (head == LAST_IDX) ? '0 : head + 1'b1;

  assign out_free = !out_valid || tx.ready;
  assign load_dlv = (state == S_DRAIN_OUT) && out_free;
  assign load_ack = (state == S_ACK) && out_free;
  assign ram_we   = (state == S_DECIDE) && sum_ok && in_window;
  assign ram_re   = (state == S_DRAIN_RD);

  srr_ram #(
    .WIDTH (srr_pkg::PAYLOAD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (payload),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_expected <= '0;
      head          <= '0;
      slot_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (byte_cnt == LAST_BYTE) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!sum_ok) begin
            state <= S_IDLE;
          end else if (in_window) begin
            slot_valid[slot_idx] <= 1'b1;
            state                <= S_DRAIN_RD;
          end else if (below_window) begin
            state <= S_ACK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DRAIN_RD: begin
          state <= slot_valid[head] ? S_DRAIN_OUT : S_ACK;
        end
        S_DRAIN_OUT: begin
          if (out_free) begin
            slot_valid[head] <= 1'b0;
            next_expected    <= next_expected + 1'b1;
            head             <= head_next;
            state            <= S_DRAIN_RD;
          end
        end
        S_ACK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load_dlv || load_ack) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq      <= rx.in_sequence;
      given    <= rx.in_checksum;
      payload  <= {rx.in_payload_high, rx.in_payload_mid, rx.in_payload_low};
      acc      <= SUM_W'({1'b0, rx.in_sequence} + {1'b0, rx.in_ack_number});
      byte_cnt <= '0;
    end else if (state == S_SUM) begin
      acc      <= acc + SUM_W'(cur_byte);
      byte_cnt <= byte_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_dlv) begin
      out_kind     <= srr_pkg::KIND_DELIVER;
      out_sequence <= next_expected;
      out_checksum <= '0;
      out_payload  <= ram_rdata;
      out_last     <= 1'b0;
    end else if (load_ack) begin
      out_kind     <= srr_pkg::KIND_ACK;
      out_sequence <= seq;
      out_checksum <= {seq, 1'b0};
      out_payload  <= '0;
      out_last     <= 1'b1;
    end
  end

  assign tx.valid            = out_valid;
  assign tx.out_kind         = out_kind;
  assign tx.out_sequence     = out_sequence;
  assign tx.out_checksum     = out_checksum;
  assign tx.out_payload_low  = out_payload[srr_pkg::LOW_W-1:0];
  assign tx.out_payload_mid  = out_payload[srr_pkg::LOW_W +: srr_pkg::MID_W];
  assign tx.out_payload_high = out_payload[srr_pkg::LOW_W + srr_pkg::MID_W +: srr_pkg::HIGH_W];
  assign tx.out_last         = out_last;

endmodule

FILE: design/srr_checker.sv
`include "selective_repeat_receiver_macros.svh"

module srr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rx_valid,
  input logic                          rx_ready,
  input logic                          tx_valid,
  input logic                          tx_ready,
  input logic                          tx_kind,
  input srr_pkg::seq_t                 tx_sequence,
  input logic [srr_pkg::OUT_CHK_W-1:0] tx_checksum,
  input logic [srr_pkg::LOW_W-1:0]     tx_payload_low,
  input logic [srr_pkg::MID_W-1:0]     tx_payload_mid,
  input logic [srr_pkg::HIGH_W-1:0]    tx_payload_high,
  input logic                          tx_last
);

  logic                      is_ack;
  logic                      is_dlv;
  logic                      ack_ok;
  logic                      dlv_ok;
  logic                      stall;
  logic [srr_pkg::SEQ_W+1:0] held;

  assign is_ack = tx_valid && (tx_kind == srr_pkg::KIND_ACK);
  assign is_dlv = tx_valid && (tx_kind == srr_pkg::KIND_DELIVER);
  assign ack_ok = tx_last && (tx_checksum == {tx_sequence, 1'b0}) &&
                  (tx_payload_low == '0) && (tx_payload_mid == '0) &&
                  (tx_payload_high == '0);
  assign dlv_ok = !tx_last && (tx_checksum == '0);
  assign stall  = tx_valid && !tx_ready;
  assign held   = {tx_kind, tx_sequence, tx_last};

  `SRR_ASSERT_NEXT(a_busy_after_accept, clk, rst, rx_valid && rx_ready, !rx_ready)

  `SRR_ASSERT_SAME(a_ack_shape, clk, rst, is_ack, ack_ok)

  `SRR_ASSERT_SAME(a_delivery_shape, clk, rst, is_dlv, dlv_ok)

  `SRR_ASSERT_NEXT(a_tx_hold, clk, rst, stall, tx_valid && $stable(held))

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_valid        (rx.valid),
  .rx_ready        (rx.ready),
  .tx_valid        (tx.valid),
  .tx_ready        (tx.ready),
  .tx_kind         (tx.out_kind),
  .tx_sequence     (tx.out_sequence),
  .tx_checksum     (tx.out_checksum),
  .tx_payload_low  (tx.out_payload_low),
  .tx_payload_mid  (tx.out_payload_mid),
  .tx_payload_high (tx.out_payload_high),
  .tx_last         (tx.out_last)
);
